>>> rtl/pf_pkg.sv
// package for the playfair digraph encryptor: payload types, square layout, codes
// and the cell lookup helper; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pf_pkg;

  localparam int unsigned SIDE       = 5;
  localparam int unsigned CELLS      = SIDE * SIDE;
  localparam int unsigned CODE_W     = 5;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned LOW_CELLS  = 12;
  localparam int unsigned HIGH_CELLS = 12;
  localparam int unsigned REG_W      = LOW_CELLS * CODE_W;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CODE_W-1:0] CODE_I = 5'd8;
  localparam logic [CODE_W-1:0] CODE_J = 5'd9;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_CELL  = 2'd2;

  localparam logic [POS_W-1:0] LAST_POS = 3'd4;

  typedef logic [CELLS-1:0][CODE_W-1:0] square_t;

  typedef struct packed {
    logic [CODE_W-1:0] first_letter;
    logic [CODE_W-1:0] second_letter;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] first_cipher;
    logic [CODE_W-1:0] second_cipher;
    logic              letter_missing;
  } out_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

  function automatic logic [CODE_W-1:0] fold_j(input logic [CODE_W-1:0] code);
    return (code == CODE_J) ? CODE_I : code;
  endfunction

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
    return (p == LAST_POS) ? '0 : p + 3'd1;
  endfunction

  function automatic logic [CODE_W-1:0] cell_at(input square_t sq,
                                                 input logic [POS_W-1:0] row,
                                                 input logic [POS_W-1:0] col);
    logic [IDX_W-1:0] idx;
    idx = {row[2:0], 2'b00} + IDX_W'(row) + IDX_W'(col);
    return sq[idx];
  endfunction

endpackage

`default_nettype wire

>>> rtl/playfair_digraph_encrypt.sv
// top level of the playfair digraph encryptor: key square registers and a
// four-stage pipeline; depends on pf_pkg and pf_locate
//
//   port group   direction   contents
//   in_*         input       valid/stall beat of one digraph (pf_pkg::in_t)
//   out_*        output      valid/stall beat of one cipher pair (pf_pkg::out_t)
//   cfg_*        input       register write: enable, index, 60-bit data
//
// one digraph per cycle unless out_stall holds it; registered in s1, s2, s3, then out_r
// stages: fold j / compare against all 25 cells / first-match encode / rule and lookup
// the whole pipeline, bubbles included, holds while a result waits under out_stall
// reset is synchronous, active low, clears valid bits and the square
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_encrypt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire pf_pkg::in_t                 in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output pf_pkg::out_t                     out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic [pf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pf_pkg::REG_W-1:0]    cfg_data
);

  logic [pf_pkg::REG_W-1:0]  cells_low_r;
  logic [pf_pkg::REG_W-1:0]  cells_high_r;
  logic [pf_pkg::CODE_W-1:0] last_cell_r;
  pf_pkg::square_t           square;

  logic adv;

  logic                      s1_valid_r;
  logic [pf_pkg::CODE_W-1:0] s1_a_r;
  logic [pf_pkg::CODE_W-1:0] s1_b_r;

  logic                      s2_valid_r;
  logic [pf_pkg::CELLS-1:0]  s2_match_a_r;
  logic [pf_pkg::CELLS-1:0]  s2_match_b_r;
  logic [pf_pkg::CELLS-1:0]  match_a_nxt;
  logic [pf_pkg::CELLS-1:0]  match_b_nxt;

  logic                      s3_valid_r;
  pf_pkg::pos_t              s3_pos_a_r;
  pf_pkg::pos_t              s3_pos_b_r;
  pf_pkg::pos_t              pos_a_nxt;
  pf_pkg::pos_t              pos_b_nxt;

  logic                      out_valid_r;
  pf_pkg::out_t              out_r;
  pf_pkg::out_t              out_nxt;

  logic [pf_pkg::POS_W-1:0]  ra;
  logic [pf_pkg::POS_W-1:0]  ca;
  logic [pf_pkg::POS_W-1:0]  rb;
  logic [pf_pkg::POS_W-1:0]  cb;

  // key square registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_low_r  <= '0;
      cells_high_r <= '0;
      last_cell_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pf_pkg::REG_CELLS_LOW:  cells_low_r  <= cfg_data;
        pf_pkg::REG_CELLS_HIGH: cells_high_r <= cfg_data;
        pf_pkg::REG_LAST_CELL:  last_cell_r  <= cfg_data[pf_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < pf_pkg::LOW_CELLS; k++) begin
      square[k] = cells_low_r[k*pf_pkg::CODE_W +: pf_pkg::CODE_W];
    end
    for (int k = 0; k < pf_pkg::HIGH_CELLS; k++) begin
      square[pf_pkg::LOW_CELLS + k] = cells_high_r[k*pf_pkg::CODE_W +: pf_pkg::CODE_W];
    end
    square[pf_pkg::CELLS-1] = last_cell_r;
  end

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // stage 1: input register with j folded to i
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a_r <= pf_pkg::fold_j(in_data.first_letter);
      s1_b_r <= pf_pkg::fold_j(in_data.second_letter);
    end
  end

  // stage 2: compare against every cell
  always_comb begin
    for (int k = 0; k < pf_pkg::CELLS; k++) begin
      match_a_nxt[k] = (square[k] == s1_a_r);
      match_b_nxt[k] = (square[k] == s1_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_match_a_r <= match_a_nxt;
      s2_match_b_r <= match_b_nxt;
    end
  end

  // stage 3: lowest-index match to row and column
  pf_locate u_locate_a (
    .match (s2_match_a_r),
    .pos   (pos_a_nxt)
  );

  pf_locate u_locate_b (
    .match (s2_match_b_r),
    .pos   (pos_b_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pos_a_r <= pos_a_nxt;
      s3_pos_b_r <= pos_b_nxt;
    end
  end

  // stage 4: same row, same column or rectangle, then cell lookup
  always_comb begin
    ra = s3_pos_a_r.row;
    ca = s3_pos_a_r.col;
    rb = s3_pos_b_r.row;
    cb = s3_pos_b_r.col;
    if (s3_pos_a_r.row == s3_pos_b_r.row) begin
      ca = pf_pkg::next_pos(s3_pos_a_r.col);
      cb = pf_pkg::next_pos(s3_pos_b_r.col);
    end else if (s3_pos_a_r.col == s3_pos_b_r.col) begin
      ra = pf_pkg::next_pos(s3_pos_a_r.row);
      rb = pf_pkg::next_pos(s3_pos_b_r.row);
    end else begin
      ca = s3_pos_b_r.col;
      cb = s3_pos_a_r.col;
    end
    if (s3_pos_a_r.found && s3_pos_b_r.found) begin
      out_nxt.first_cipher   = pf_pkg::cell_at(square, ra, ca);
      out_nxt.second_cipher  = pf_pkg::cell_at(square, rb, cb);
      out_nxt.letter_missing = 1'b0;
    end else begin
      out_nxt.first_cipher   = '0;
      out_nxt.second_cipher  = '0;
      out_nxt.letter_missing = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.letter_missing |->
      out_r.first_cipher == '0 && out_r.second_cipher == '0)
    else $error("missing letter with nonzero cipher");

  a_no_j_after_fold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> s1_a_r != pf_pkg::CODE_J && s1_b_r != pf_pkg::CODE_J)
    else $error("j reached the compare stage");

  a_pos_in_square: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && s3_pos_a_r.found && s3_pos_b_r.found |->
      s3_pos_a_r.row <= pf_pkg::LAST_POS && s3_pos_a_r.col <= pf_pkg::LAST_POS &&
      s3_pos_b_r.row <= pf_pkg::LAST_POS && s3_pos_b_r.col <= pf_pkg::LAST_POS)
    else $error("position outside the square");

  a_hold_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s3_valid_r) && $stable(s3_pos_a_r) && $stable(s3_pos_b_r))
    else $error("stage 3 moved during a stall");
`endif

endmodule

`default_nettype wire

>>> rtl/pf_locate.sv
// first-match encoder: turns a 25-cell match vector into found flag, row and column
// depends on pf_pkg
`timescale 1ns / 1ps
`default_nettype none

module pf_locate (
  input  wire logic [pf_pkg::CELLS-1:0] match,
  output pf_pkg::pos_t                  pos
);

  logic [pf_pkg::SIDE-1:0]  row_bits;
  logic [pf_pkg::POS_W-1:0] row;
  logic [pf_pkg::POS_W-1:0] col;

  always_comb begin
    row      = '0;
    row_bits = '0;
    for (int r = pf_pkg::SIDE - 1; r >= 0; r--) begin
      if (|match[r*pf_pkg::SIDE +: pf_pkg::SIDE]) begin
        row      = pf_pkg::POS_W'(r);
        row_bits = match[r*pf_pkg::SIDE +: pf_pkg::SIDE];
      end
    end
    col = '0;
    for (int c = pf_pkg::SIDE - 1; c >= 0; c--) begin
      if (row_bits[c]) begin
        col = pf_pkg::POS_W'(c);
      end
    end
  end

  assign pos.found = |match;
  assign pos.row   = row;
  assign pos.col   = col;

endmodule

`default_nettype wire

>>> tb/sv/playfair_digraph_encrypt_test.sv
// self-checking testbench for playfair_digraph_encrypt: random valid/stall traffic,
// key square loads through the cfg port, and a scoreboard of predicted cipher pairs
// depends on pf_pkg and the playfair_digraph_encrypt rtl
`timescale 1ns / 1ps

module playfair_digraph_encrypt_test;

  localparam logic [pf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 212;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  pf_pkg::in_t                  in_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  pf_pkg::out_t                 out_data;
  logic                         cfg_wr_en = 1'b0;
  logic [pf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pf_pkg::REG_W-1:0]     cfg_data = '0;

  pf_pkg::square_t key_grid = '0;
  pf_pkg::in_t     digraph_queue[$];
  pf_pkg::out_t    cipher_due[$];
  int      mismatch_count = 0;
  int      send_gap = 0;
  int      recv_gap = 0;
  int      hold_left = 0;
  int      hold_asks = 0;
  int      hold_served = 0;
  int      quiet_cycles = 0;
  bit      no_idle = 1'b0;

  playfair_digraph_encrypt u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic pf_pkg::out_t encipher(pf_pkg::in_t d);
    logic [pf_pkg::CODE_W-1:0] a, b;
    int pa, pb, ra, ca, rb, cb, t;
    pf_pkg::out_t r;
    a = (d.first_letter == pf_pkg::CODE_J) ? pf_pkg::CODE_I : d.first_letter;
    b = (d.second_letter == pf_pkg::CODE_J) ? pf_pkg::CODE_I : d.second_letter;
    pa = -1;
    pb = -1;
    // scan downward so the lowest matching cell is kept
    for (int i = pf_pkg::CELLS - 1; i >= 0; i--) begin
      if (key_grid[i] == a) pa = i;
      if (key_grid[i] == b) pb = i;
    end
    r = '0;
    if (pa < 0 || pb < 0) begin
      r.letter_missing = 1'b1;
      return r;
    end
    ra = pa / pf_pkg::SIDE;
    ca = pa % pf_pkg::SIDE;
    rb = pb / pf_pkg::SIDE;
    cb = pb % pf_pkg::SIDE;
    if (ra == rb) begin
      ca = (ca + 1) % pf_pkg::SIDE;
      cb = (cb + 1) % pf_pkg::SIDE;
    end else if (ca == cb) begin
      ra = (ra + 1) % pf_pkg::SIDE;
      rb = (rb + 1) % pf_pkg::SIDE;
    end else begin
      t = ca;
      ca = cb;
      cb = t;
    end
    r.first_cipher = key_grid[ra * pf_pkg::SIDE + ca];
    r.second_cipher = key_grid[rb * pf_pkg::SIDE + cb];
    return r;
  endfunction

  function automatic logic [pf_pkg::CODE_W-1:0] ltr(byte c);
    return pf_pkg::CODE_W'(c - 8'd65);
  endfunction

  function automatic logic [pf_pkg::CODE_W-1:0] rand_letter();
    if ($urandom_range(0, 9) == 0) return pf_pkg::CODE_W'($urandom_range(26, 31));
    return pf_pkg::CODE_W'($urandom_range(0, 25));
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_pair(input logic [pf_pkg::CODE_W-1:0] a,
                           input logic [pf_pkg::CODE_W-1:0] b);
    pf_pkg::in_t d;
    d.first_letter = a;
    d.second_letter = b;
    digraph_queue.push_back(d);
  endtask

  task automatic write_reg(input logic [pf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pf_pkg::REG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      pf_pkg::REG_CELLS_LOW:  key_grid[pf_pkg::LOW_CELLS-1:0] = val;
      pf_pkg::REG_CELLS_HIGH:
        key_grid[pf_pkg::LOW_CELLS+pf_pkg::HIGH_CELLS-1:pf_pkg::LOW_CELLS] = val;
      pf_pkg::REG_LAST_CELL:  key_grid[pf_pkg::CELLS-1] = val[pf_pkg::CODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_square(input pf_pkg::square_t g);
    write_reg(pf_pkg::REG_CELLS_LOW, g[pf_pkg::LOW_CELLS-1:0]);
    write_reg(pf_pkg::REG_CELLS_HIGH,
              g[pf_pkg::LOW_CELLS+pf_pkg::HIGH_CELLS-1:pf_pkg::LOW_CELLS]);
    write_reg(pf_pkg::REG_LAST_CELL, pf_pkg::REG_W'(g[pf_pkg::CELLS-1]));
  endtask

  task automatic square_from_text(input string s, output pf_pkg::square_t g);
    for (int i = 0; i < pf_pkg::CELLS; i++) g[i] = ltr(s[i]);
  endtask

  task automatic shuffled_square(output pf_pkg::square_t g);
    int n, j;
    logic [pf_pkg::CODE_W-1:0] tmp;
    n = 0;
    for (int c = 0; c < 26; c++) begin
      if (c != int'(pf_pkg::CODE_J)) begin
        g[n] = pf_pkg::CODE_W'(c);
        n++;
      end
    end
    for (int i = pf_pkg::CELLS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = g[i];
      g[i] = g[j];
      g[j] = tmp;
    end
  endtask

  task automatic scattered_square(output pf_pkg::square_t g, input int top);
    for (int i = 0; i < pf_pkg::CELLS; i++) g[i] = pf_pkg::CODE_W'($urandom_range(0, top));
  endtask

  task automatic drain();
    do @(negedge clk);
    while (digraph_queue.size() != 0 || in_valid || cipher_due.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        cipher_due.push_back(encipher(in_data));
        send_gap = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (in_valid && in_stall) begin
        // hold the beat
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (digraph_queue.size() != 0) begin
        in_data <= digraph_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) recv_gap = no_idle ? 0 : $urandom_range(0, 19);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    pf_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_due.size() == 0) begin
        flag_mismatch("unexpected beat, letter_missing", int'(out_data.letter_missing), 0);
      end else begin
        want = cipher_due.pop_front();
        if (out_data.first_cipher !== want.first_cipher)
          flag_mismatch("first_cipher", int'(out_data.first_cipher), int'(want.first_cipher));
        if (out_data.second_cipher !== want.second_cipher)
          flag_mismatch("second_cipher", int'(out_data.second_cipher),
                        int'(want.second_cipher));
        if (out_data.letter_missing !== want.letter_missing)
          flag_mismatch("letter_missing", int'(out_data.letter_missing),
                        int'(want.letter_missing));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    pf_pkg::square_t g;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // square still all zero after reset
    @(negedge clk);
    push_pair(5'd0, 5'd0);
    push_pair(5'd0, 5'd1);
    drain();

    square_from_text("PLAYFIREXMBCDGHKNOQSTUVWZ", g);
    load_square(g);
    write_reg(REG_UNUSED, '1);
    @(negedge clk);
    push_pair(ltr("P"), ltr("L"));
    push_pair(ltr("F"), ltr("P"));
    push_pair(ltr("P"), ltr("T"));
    push_pair(ltr("H"), ltr("Z"));
    push_pair(ltr("A"), ltr("A"));
    push_pair(ltr("J"), ltr("R"));
    push_pair(ltr("I"), ltr("Z"));
    push_pair(ltr("Z"), ltr("A"));
    push_pair(5'd0, 5'd25);
    push_pair(5'd25, 5'd0);
    push_pair(5'd31, 5'd0);
    push_pair(5'd0, 5'd31);
    push_pair(5'd26, 5'd26);
    push_pair(pf_pkg::CODE_J, pf_pkg::CODE_J);
    drain();

    // j sits in the square in place of i, so it can never be found
    square_from_text("PLAYFJREXMBCDGHKNOQSTUVWZ", g);
    load_square(g);
    @(negedge clk);
    push_pair(pf_pkg::CODE_I, ltr("A"));
    push_pair(pf_pkg::CODE_J, ltr("A"));
    drain();

    write_reg(pf_pkg::REG_CELLS_LOW, '1);
    write_reg(pf_pkg::REG_CELLS_HIGH, '1);
    write_reg(pf_pkg::REG_LAST_CELL, pf_pkg::REG_W'(25));
    @(negedge clk);
    push_pair(5'd31, 5'd31);
    push_pair(5'd31, 5'd25);
    push_pair(5'd25, 5'd25);
    drain();

    write_reg(pf_pkg::REG_CELLS_LOW, '0);
    write_reg(pf_pkg::REG_CELLS_HIGH, '0);
    write_reg(pf_pkg::REG_LAST_CELL, '0);
    @(negedge clk);
    push_pair(5'd0, 5'd0);
    push_pair(5'd0, 5'd31);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 2) scattered_square(g, 25);
      else if (p == 4) scattered_square(g, 31);
      else shuffled_square(g);
      load_square(g);
      @(negedge clk);
      no_idle = (p == 5);
      if (p == 1) hold_asks++;
      for (int n = 0; n < PHASE_ITEMS; n++) push_pair(rand_letter(), rand_letter());
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pf_pkg.sv
rtl/pf_locate.sv
rtl/playfair_digraph_encrypt.sv
tb/sv/playfair_digraph_encrypt_test.sv
